@@ hw/rtl/pot_to_pwm_setting_mapper_macros.svh @@
// Assertion macros for the pot-to-PWM setting mapper.
// Used by the top level; expects clk and rst_n in scope.
`ifndef POT_TO_PWM_SETTING_MAPPER_MACROS_SVH
`define POT_TO_PWM_SETTING_MAPPER_MACROS_SVH

// ante true -> cons true in the same cycle
`define PPSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true -> cons true in the next cycle
`define PPSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ppsm_pkg.sv @@
// Shared constants for the pot-to-PWM setting mapper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppsm_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam int CLK_W    = 27;
    localparam int PERIOD_W = 20;
    localparam int PCT_W    = 7;
    localparam int FREQ_W   = 17;
    localparam int MAPQ_W   = 10;   // frequency step index, 0..999
    localparam int MULK_W   = 10;   // width of the mapping multiplier constant

    localparam int FREQ_STEPS = 999;
    localparam int FREQ_UNIT  = 100;
    localparam int PCT_FULL   = 100;

    localparam logic [CLK_W-1:0]    CLOCK_HZ_RST = CLK_W'(15000000);
    localparam logic [FREQ_W-1:0]   FREQ_RST     = FREQ_W'(1000);
    localparam logic [PCT_W-1:0]    PCT_RST      = PCT_W'(50);
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(15000);
    localparam logic [PERIOD_W-1:0] DUTY_RST     = PERIOD_W'(7500);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // adjust modes
    localparam logic MODE_FREQ = 1'b0;
    localparam logic MODE_DUTY = 1'b1;

    // APB register offsets (bit 2 of the byte address selects the word)
    localparam logic REG_CLOCK_HZ = 1'b0;

endpackage

`default_nettype wire

@@ hw/rtl/ppsm_ifs.sv @@
// Item channels of the pot-to-PWM setting mapper: command in, settings out.
// Depends on ppsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppsm_cmd_if
    import ppsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface ppsm_rsp_if
    import ppsm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_ticks;
    logic [PERIOD_W-1:0] duty_ticks;
    logic [PCT_W-1:0]    duty_percent;
    logic [FREQ_W-1:0]   frequency_hz;
    logic                adjust_mode;
    logic                updated;

    modport source (output valid, output period_ticks, output duty_ticks,
                    output duty_percent, output frequency_hz, output adjust_mode,
                    output updated, input ready);
    modport sink   (input valid, input period_ticks, input duty_ticks,
                    input duty_percent, input frequency_hz, input adjust_mode,
                    input updated, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ppsm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ppsm_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;   // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] rem_sub;
    logic           fits;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pot_to_pwm_setting_mapper.sv @@
// Sequence: a button press or dropped sample goes straight to S_OUT; a duty change runs
//   the map and duty divisions, a frequency change the map, period and duty divisions.
// Throughput: one item at a time; the single shared bit-serial divider sets the figure,
//   one quotient bit per cycle. A finished result may wait while the next item is taken.
// Reset: asynchronous active-low rst_n restores clock_hz = 15000000, 1000 Hz, 50 %.
`timescale 1ns / 1ps
`default_nettype none
`include "pot_to_pwm_setting_mapper_macros.svh"

// Potentiometer to PWM setting mapper, top level.
// Depends on ppsm_pkg, ppsm_ifs (channels) and ppsm_div.
module pot_to_pwm_setting_mapper
    import ppsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ppsm_cmd_if.sink         cmd,
    ppsm_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Divider sizing: numerator covers clock_hz, sample*999 and period*(100-percent);
    // denominator covers frequency and the full-scale sample value.
    localparam int MAP_W = SAMPLE_BITS + MULK_W;
    localparam int NUM_W = (MAP_W > CLK_W) ? MAP_W : CLK_W;
    localparam int DEN_W = (SAMPLE_BITS > FREQ_W) ? SAMPLE_BITS : FREQ_W;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // Sequencer
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] S_MAP   = 3'd1;  // sample -> frequency step or percent
    localparam logic [2:0] S_PLOAD = 3'd2;  // launch clock_hz / frequency
    localparam logic [2:0] S_PER   = 3'd3;  // wait for period
    localparam logic [2:0] S_DLOAD = 3'd4;  // launch period*(100-pct) / 100
    localparam logic [2:0] S_DUTY  = 3'd5;  // wait for duty
    localparam logic [2:0] S_OUT   = 3'd6;  // hand result to the output register

    logic [2:0]             state_reg;
    logic [CLK_W-1:0]       clock_hz_reg;
    logic [SAMPLE_BITS-1:0] last_sample_reg;
    logic                   mode_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [PCT_W-1:0]       pct_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [PERIOD_W-1:0]    duty_reg;
    logic                   upd_reg;

    // output register
    logic                   rsp_valid_reg;
    logic [PERIOD_W-1:0]    rsp_period_reg;
    logic [PERIOD_W-1:0]    rsp_duty_reg;
    logic [PCT_W-1:0]       rsp_pct_reg;
    logic [FREQ_W-1:0]      rsp_freq_reg;
    logic                   rsp_mode_reg;
    logic                   rsp_upd_reg;

    logic                   cmd_fire;
    logic                   cfg_write;
    logic                   rsp_free;
    logic [SAMPLE_BITS-1:0] s_diff;
    logic                   s_moved;
    logic [MULK_W-1:0]      map_k;
    logic [MAP_W-1:0]       map_prod;
    logic [FREQ_W-1:0]      f_calc;
    logic [PCT_W-1:0]       p_calc;
    logic [PERIOD_W+PCT_W-1:0] duty_prod;
    logic [PERIOD_W-1:0]    period_sat;

    logic                   div_start;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [NUM_W-1:0]       div_quo;
    logic                   div_done;

    // ---------------- APB configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CLOCK_HZ) ? 32'(clock_hz_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RST;
        end
        else if (cfg_write && (paddr[2] == REG_CLOCK_HZ))
        begin
            clock_hz_reg <= pwdata[CLK_W-1:0];
        end
    end

    // ---------------- Datapath helpers ----------------
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // dead band: a sample must move by more than one code
    assign s_diff  = (cmd.sample > last_sample_reg) ? (cmd.sample - last_sample_reg)
                                                    : (last_sample_reg - cmd.sample);
    assign s_moved = |s_diff[SAMPLE_BITS-1:1];

    assign map_k    = (mode_reg == MODE_DUTY) ? MULK_W'(PCT_FULL) : MULK_W'(FREQ_STEPS);
    assign map_prod = MAP_W'(cmd.sample) * MAP_W'(map_k);

    // divider quotient -> frequency (step+1)*100, or percent
    assign f_calc = (FREQ_W'(div_quo[MAPQ_W-1:0]) + FREQ_W'(1)) * FREQ_W'(FREQ_UNIT);
    assign p_calc = div_quo[PCT_W-1:0];

    assign duty_prod  = (PERIOD_W+PCT_W)'(period_reg) *
                        (PERIOD_W+PCT_W)'(PCT_W'(PCT_FULL) - pct_reg);
    // quotient above the 20-bit field clamps to all ones
    assign period_sat = (|div_quo[NUM_W-1:PERIOD_W]) ? PERIOD_MAX : div_quo[PERIOD_W-1:0];

    // divider operand selection
    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUM_W'(map_prod);
        div_den   = DEN_W'(SAMPLE_MAX);
        case (state_reg)
            S_IDLE:
            begin
                div_start = cmd_fire && (cmd.opcode == OP_SAMPLE) && s_moved;
            end
            S_PLOAD:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(clock_hz_reg);
                div_den   = DEN_W'(freq_reg);
            end
            S_DLOAD:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(duty_prod);
                div_den   = DEN_W'(PCT_FULL);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ppsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // ---------------- Sequencer and settings ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            last_sample_reg <= '0;
            mode_reg        <= MODE_FREQ;
            freq_reg        <= FREQ_RST;
            pct_reg         <= PCT_RST;
            period_reg      <= PERIOD_RST;
            duty_reg        <= DUTY_RST;
            upd_reg         <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        upd_reg <= 1'b0;
                        if (cmd.opcode == OP_BUTTON)
                        begin
                            mode_reg  <= ~mode_reg;
                            state_reg <= S_OUT;
                        end
                        else if (s_moved)
                        begin
                            last_sample_reg <= cmd.sample;
                            state_reg       <= S_MAP;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MAP:
                begin
                    if (div_done)
                    begin
                        if (mode_reg == MODE_FREQ)
                        begin
                            if (f_calc != freq_reg)
                            begin
                                freq_reg  <= f_calc;
                                upd_reg   <= 1'b1;
                                state_reg <= S_PLOAD;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                        else
                        begin
                            if (p_calc != pct_reg)
                            begin
                                pct_reg   <= p_calc;
                                upd_reg   <= 1'b1;
                                state_reg <= S_DLOAD;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                    end
                end
                S_PLOAD:
                begin
                    state_reg <= S_PER;
                end
                S_PER:
                begin
                    if (div_done)
                    begin
                        period_reg <= period_sat;
                        state_reg  <= S_DLOAD;
                    end
                end
                S_DLOAD:
                begin
                    state_reg <= S_DUTY;
                end
                S_DUTY:
                begin
                    if (div_done)
                    begin
                        duty_reg  <= div_quo[PERIOD_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (rsp_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && rsp_free)
        begin
            rsp_period_reg <= period_reg;
            rsp_duty_reg   <= duty_reg;
            rsp_pct_reg    <= pct_reg;
            rsp_freq_reg   <= freq_reg;
            rsp_mode_reg   <= mode_reg;
            rsp_upd_reg    <= upd_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.period_ticks = rsp_period_reg;
    assign rsp.duty_ticks   = rsp_duty_reg;
    assign rsp.duty_percent = rsp_pct_reg;
    assign rsp.frequency_hz = rsp_freq_reg;
    assign rsp.adjust_mode  = rsp_mode_reg;
    assign rsp.updated      = rsp_upd_reg;

    // ---------------- Assertions ----------------
    // divider results only arrive while the sequencer waits for one
    `PPSM_ASSERT_SAME(a_div_done_state,
        div_done,
        (state_reg == S_MAP) || (state_reg == S_PER) || (state_reg == S_DUTY),
        "divider finished outside a wait state")

    // an accepted item always starts work
    `PPSM_ASSERT_NEXT(a_busy_after_accept,
        cmd_fire,
        state_reg != S_IDLE,
        "sequencer idle right after an accepted item")

    // a finished item must not overwrite a result that is still waiting
    `PPSM_ASSERT_NEXT(a_out_holds,
        (state_reg == S_OUT) && rsp_valid_reg && !rsp.ready,
        (state_reg == S_OUT) && rsp_valid_reg,
        "result dropped while the output was stalled")

endmodule

`default_nettype wire

@@ tb/pot_to_pwm_setting_mapper_tb.sv @@
// Testbench for the pot-to-PWM setting mapper: directed and random commands,
// APB clock_hz writes between phases, results checked against a local predictor.
// Depends on ppsm_pkg, ppsm_ifs and the mapper RTL.
`timescale 1ns / 1ps

module pot_to_pwm_setting_mapper_tb;
    import ppsm_pkg::*;

    localparam int SMP_MAX       = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES = 128;        // outlasts the longest item (a frequency change)
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASE_ITEMS   = 106;

    // One settings item, fields in the order of the result channel
    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [PERIOD_W-1:0] duty_ticks;
        logic [PCT_W-1:0]    duty_percent;
        logic [FREQ_W-1:0]   frequency_hz;
        logic                adjust_mode;
        logic                updated;
    } settings_t;

    // Tracks the mapper's state, predicts the settings each command gives
    // and checks the settings that come back, oldest first.
    class pwm_setting_tracker;
        logic [CLK_W-1:0]           clock_hz;
        logic [SAMPLE_BITS_DEF-1:0] last_smp;
        logic                       mode;
        logic [FREQ_W-1:0]          freq;
        logic [PCT_W-1:0]           pct;
        logic [PERIOD_W-1:0]        period;
        logic [PERIOD_W-1:0]        duty;
        settings_t                  pending_settings[$];
        int                         errors;

        function new();
            clock_hz = CLOCK_HZ_RST;
            last_smp = '0;
            mode     = MODE_FREQ;
            freq     = FREQ_RST;
            pct      = PCT_RST;
            period   = PERIOD_RST;
            duty     = DUTY_RST;
            errors   = 0;
        endfunction

        function logic [PERIOD_W-1:0] duty_for();
            return PERIOD_W'((longint'(period) * (PCT_FULL - pct)) / PCT_FULL);
        endfunction

        function void note_command(logic op, logic [SAMPLE_BITS_DEF-1:0] smp);
            int unsigned     s;
            int unsigned     jump;
            int unsigned     f;
            int unsigned     p;
            longint unsigned q;
            logic            upd;
            upd = 1'b0;
            if (op == OP_BUTTON)
                mode = ~mode;
            else
            begin
                s    = smp;
                jump = (s > last_smp) ? s - last_smp : last_smp - s;
                // jitter of one count is dropped without touching anything
                if (jump > 1)
                begin
                    last_smp = smp;
                    if (mode == MODE_FREQ)
                    begin
                        f = (s * FREQ_STEPS / SMP_MAX + 1) * FREQ_UNIT;
                        if (f != freq)
                        begin
                            freq = FREQ_W'(f);
                            q = clock_hz / f;
                            if (q > PERIOD_MAX)
                                q = PERIOD_MAX;
                            period = PERIOD_W'(q);
                            duty   = duty_for();
                            upd    = 1'b1;
                        end
                    end
                    else
                    begin
                        p = s * PCT_FULL / SMP_MAX;
                        if (p != pct)
                        begin
                            pct  = PCT_W'(p);
                            duty = duty_for();
                            upd  = 1'b1;
                        end
                    end
                end
            end
            pending_settings.push_back({period, duty, pct, freq, mode, upd});
        endfunction

        function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_settings(settings_t got);
            settings_t exp_s;
            if (pending_settings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected settings item, expected none, got %h", $time, got);
                return;
            end
            exp_s = pending_settings.pop_front();
            check_field("period_ticks", exp_s.period_ticks, got.period_ticks);
            check_field("duty_ticks",   exp_s.duty_ticks,   got.duty_ticks);
            check_field("duty_percent", exp_s.duty_percent, got.duty_percent);
            check_field("frequency_hz", exp_s.frequency_hz, got.frequency_hz);
            check_field("adjust_mode",  exp_s.adjust_mode,  got.adjust_mode);
            check_field("updated",      exp_s.updated,      got.updated);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          cycles;
    bit          steady;     // set for stretches where the sender never idles

    pwm_setting_tracker tracker;

    ppsm_cmd_if cmd_ch ();
    ppsm_rsp_if rsp_ch ();

    pot_to_pwm_setting_mapper DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap before an item: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command and hold it until the mapper takes it.
    // valid stays high between back-to-back items (no drop/raise in one step).
    task automatic send_item(logic op, logic [SAMPLE_BITS_DEF-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.sample <= smp;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.note_command(op, smp);
    endtask

    // Stop sending and let every outstanding item come back, then let the
    // divider run out before anything else happens.
    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        while (tracker.pending_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of clock_hz: setup cycle, then access until pready
    task automatic write_clock_hz(logic [CLK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CLOCK_HZ, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // new clock only matters at the next frequency change
        tracker.clock_hz = value;
    endtask

    // Random commands: buttons, jitter around the last accepted sample,
    // the ends of the pot range, and uniform samples.
    task automatic run_phase(int count);
        int r;
        int s;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 15)
                send_item(OP_BUTTON, SAMPLE_BITS_DEF'($urandom));
            else if (r < 40)
            begin
                s = int'(tracker.last_smp) + $urandom_range(0, 6) - 3;
                if (s < 0)
                    s = 0;
                if (s > SMP_MAX)
                    s = SMP_MAX;
                send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(s));
            end
            else if (r < 52)
            begin
                case ($urandom_range(0, 3))
                    0:       s = 0;
                    1:       s = 1;
                    2:       s = SMP_MAX - 1;
                    default: s = SMP_MAX;
                endcase
                send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(s));
            end
            else
                send_item(OP_SAMPLE, SAMPLE_BITS_DEF'($urandom));
        end
        steady = 1'b0;
    endtask

    // Result side: ready drops at random, mostly briefly, now and then for long,
    // with occasional long runs where it stays high.
    initial
    begin
        int r;
        rsp_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r >= 50)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ((r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Every settings item taken is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_settings({rsp_ch.period_ticks, rsp_ch.duty_ticks,
                                    rsp_ch.duty_percent, rsp_ch.frequency_hz,
                                    rsp_ch.adjust_mode, rsp_ch.updated});
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        tracker = new();
        cycles  = 0;
        steady  = 1'b0;
        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.opcode <= OP_SAMPLE;
        cmd_ch.sample <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset clock (15 MHz), frequency mode
        send_item(OP_SAMPLE, 10'd0);        // same as reset last sample: dropped
        send_item(OP_SAMPLE, 10'd1);        // one count of jitter: dropped
        send_item(OP_SAMPLE, 10'd1023);     // top of range, 100 kHz
        send_item(OP_SAMPLE, 10'd1022);     // jitter again
        send_item(OP_SAMPLE, 10'd1021);     // accepted, just below the top
        send_item(OP_SAMPLE, 10'd0);        // 100 Hz, longest period
        send_item(OP_SAMPLE, 10'd2);        // smallest accepted step
        send_item(OP_SAMPLE, 10'd100);
        send_item(OP_BUTTON, 10'd1023);     // to duty mode, sample field ignored
        send_item(OP_SAMPLE, 10'd1023);     // 100 %, duty compare 0
        send_item(OP_SAMPLE, 10'd0);        // 0 %, duty compare = period
        send_item(OP_SAMPLE, 10'd512);      // 50 %
        send_item(OP_SAMPLE, 10'd514);      // accepted, percent unchanged
        send_item(OP_SAMPLE, 10'h2AA);
        send_item(OP_SAMPLE, 10'h155);
        send_item(OP_BUTTON, 10'h2AA);      // back to frequency mode
        send_item(OP_SAMPLE, 10'd100);      // frequency unchanged, updated stays low
        send_item(OP_SAMPLE, 10'h3FF);
        send_item(OP_BUTTON, 10'h155);
        send_item(OP_BUTTON, 10'h000);      // two presses: mode back where it was

        // Sender holds off until all settings are back before each clock change
        quiesce();
        write_clock_hz(CLK_W'(1000000));    // lowest source clock
        run_phase(PHASE_ITEMS);
        quiesce();
        write_clock_hz(CLK_W'(100000000));  // highest in-range source clock
        run_phase(PHASE_ITEMS);
        quiesce();
        write_clock_hz('1);                 // all ones: period saturates at 100 Hz
        run_phase(PHASE_ITEMS);
        quiesce();
        write_clock_hz(CLK_W'($urandom_range(1000000, 100000000)));
        run_phase(PHASE_ITEMS);
        quiesce();
        write_clock_hz(CLOCK_HZ_RST);
        run_phase(PHASE_ITEMS);

        quiesce();
        if (tracker.errors == 0 && tracker.pending_settings.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
